/* sv/tcpq_pkg.sv */
// Package for the two-class priority queue: sizes, widths, opcodes and controller states.
package tcpq_pkg;

  localparam int FAST_DEPTH  = 4096;
  localparam int EVENT_DEPTH = 64;
  localparam int WORD_BITS   = 64;

  localparam int FAST_PTR_W  = $clog2(FAST_DEPTH);
  localparam int FAST_CNT_W  = $clog2(FAST_DEPTH + 1);
  localparam int EVENT_PTR_W = $clog2(EVENT_DEPTH);
  localparam int EVENT_CNT_W = $clog2(EVENT_DEPTH + 1);

  localparam int OPCODE_W     = 2;
  localparam int PACKET_W     = 64;
  localparam int FAST_FILL_W  = 13;
  localparam int EVENT_FILL_W = 7;
  localparam int DECIM_W      = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FAST  = 2'd0,
    OP_PUSH_EVENT = 2'd1,
    OP_POP        = 2'd2
  } opcode_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

/* sv/two_class_priority_queue_drop_oldest_core.sv */
// Two-class packet queue with drop-oldest overflow, event class served first.
//
//  channel   direction  handshake              payload
//  in_       input      in_valid / in_stall    in_opcode, in_packet_in
//  out_      output     out_valid / out_stall  out_pop_valid, out_packet_out,
//                                              out_from_event_class, out_displaced,
//                                              out_fast_fill, out_event_fill
//  cfg_      input      cfg_valid / cfg_ready  cfg_data (fast decimation)
//
// A push, an unused opcode or a pop that finds both queues empty puts its word
// straight into the output register. A pop that returns a packet first passes
// through ST_READ, since the queue memories have a registered read port.
// Reset clears pointers, counts and the decimation counter at once; the memories
// are not cleared, since only occupied entries are ever returned. A word may be taken
// while the result of the previous word still waits: in_stall rises only during
// a memory read or while a held result is stalled by out_stall.
module two_class_priority_queue_drop_oldest_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tcpq_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic [tcpq_pkg::PACKET_W-1:0]        in_packet_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_pop_valid,
  output logic [tcpq_pkg::PACKET_W-1:0]        out_packet_out,
  output logic                                 out_from_event_class,
  output logic                                 out_displaced,
  output logic [tcpq_pkg::FAST_FILL_W-1:0]     out_fast_fill,
  output logic [tcpq_pkg::EVENT_FILL_W-1:0]    out_event_fill,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcpq_pkg::DECIM_W-1:0]         cfg_data
);
  import tcpq_pkg::*;

  localparam logic [FAST_PTR_W-1:0]  FAST_LAST  = FAST_PTR_W'(FAST_DEPTH - 1);
  localparam logic [EVENT_PTR_W-1:0] EVENT_LAST = EVENT_PTR_W'(EVENT_DEPTH - 1);
  localparam logic [FAST_CNT_W-1:0]  FAST_FULL  = FAST_CNT_W'(FAST_DEPTH);
  localparam logic [EVENT_CNT_W-1:0] EVENT_FULL = EVENT_CNT_W'(EVENT_DEPTH);

  // Queue memories: one write port and one registered read port each.
  logic [WORD_BITS-1:0] fast_mem  [FAST_DEPTH];
  logic [WORD_BITS-1:0] event_mem [EVENT_DEPTH];
  logic [WORD_BITS-1:0] fast_rdata_r;
  logic [WORD_BITS-1:0] event_rdata_r;

  // Control state.
  state_t                 state_r, state_nxt;
  logic [FAST_PTR_W-1:0]  fast_rd_ptr_r, fast_rd_ptr_nxt;
  logic [FAST_PTR_W-1:0]  fast_wr_ptr_r, fast_wr_ptr_nxt;
  logic [FAST_CNT_W-1:0]  fast_cnt_r, fast_cnt_nxt;
  logic [EVENT_PTR_W-1:0] event_rd_ptr_r, event_rd_ptr_nxt;
  logic [EVENT_PTR_W-1:0] event_wr_ptr_r, event_wr_ptr_nxt;
  logic [EVENT_CNT_W-1:0] event_cnt_r, event_cnt_nxt;
  logic [DECIM_W-1:0]     decim_cnt_r, decim_cnt_nxt;
  logic [DECIM_W-1:0]     decim_cfg_r;
  logic                   pop_event_r, pop_event_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 pop_valid_r, pop_valid_nxt;
  logic [PACKET_W-1:0]  packet_r, packet_nxt;
  logic                 from_event_r, from_event_nxt;
  logic                 displaced_r, displaced_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 fast_we;
  logic                 event_we;
  logic [WORD_BITS-1:0] word_in;
  logic [DECIM_W-1:0]   decim_inc;

  assign word_in   = in_packet_in[WORD_BITS-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign accept    = in_valid && !in_stall;
  assign decim_inc = decim_cnt_r + DECIM_W'(1);
  assign cfg_ready = 1'b1;

  // Next state: a pop that hits data passes through ST_READ to wait for the memory.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && opcode_t'(in_opcode) == OP_POP &&
            (event_cnt_r != '0 || fast_cnt_r != '0)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs of the controller.
  always_comb begin
    case (state_r)
      ST_IDLE: in_stall = !out_free;
      ST_READ: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  // Pointer, count and result updates.
  always_comb begin
    fast_rd_ptr_nxt  = fast_rd_ptr_r;
    fast_wr_ptr_nxt  = fast_wr_ptr_r;
    fast_cnt_nxt     = fast_cnt_r;
    event_rd_ptr_nxt = event_rd_ptr_r;
    event_wr_ptr_nxt = event_wr_ptr_r;
    event_cnt_nxt    = event_cnt_r;
    decim_cnt_nxt    = decim_cnt_r;
    pop_event_nxt    = pop_event_r;
    fast_we          = 1'b0;
    event_we         = 1'b0;

    out_valid_nxt  = out_valid_r && out_stall;
    pop_valid_nxt  = pop_valid_r;
    packet_nxt     = packet_r;
    from_event_nxt = from_event_r;
    displaced_nxt  = displaced_r;

    if (state_r == ST_READ) begin
      // Load the popped word; fills were already updated at accept.
      out_valid_nxt  = 1'b1;
      pop_valid_nxt  = 1'b1;
      from_event_nxt = pop_event_r;
      displaced_nxt  = 1'b0;
      packet_nxt     = pop_event_r ? PACKET_W'(event_rdata_r) : PACKET_W'(fast_rdata_r);
    end else if (accept) begin
      pop_valid_nxt  = 1'b0;
      packet_nxt     = '0;
      from_event_nxt = 1'b0;
      displaced_nxt  = 1'b0;
      out_valid_nxt  = 1'b1;
      case (opcode_t'(in_opcode))
        OP_PUSH_FAST: begin
          if (decim_inc >= decim_cfg_r) begin
            decim_cnt_nxt   = '0;
            fast_we         = 1'b1;
            fast_wr_ptr_nxt = (fast_wr_ptr_r == FAST_LAST) ? '0 : fast_wr_ptr_r + 1'b1;
            if (fast_cnt_r == FAST_FULL) begin
              // Drop the oldest fast entry.
              displaced_nxt   = 1'b1;
              fast_rd_ptr_nxt = (fast_rd_ptr_r == FAST_LAST) ? '0 : fast_rd_ptr_r + 1'b1;
            end else begin
              fast_cnt_nxt = fast_cnt_r + 1'b1;
            end
          end else begin
            decim_cnt_nxt = decim_inc;
          end
        end
        OP_PUSH_EVENT: begin
          event_we         = 1'b1;
          event_wr_ptr_nxt = (event_wr_ptr_r == EVENT_LAST) ? '0 : event_wr_ptr_r + 1'b1;
          if (event_cnt_r == EVENT_FULL) begin
            // Drop the oldest event.
            displaced_nxt    = 1'b1;
            event_rd_ptr_nxt = (event_rd_ptr_r == EVENT_LAST) ? '0 : event_rd_ptr_r + 1'b1;
          end else begin
            event_cnt_nxt = event_cnt_r + 1'b1;
          end
        end
        OP_POP: begin
          if (event_cnt_r != '0) begin
            out_valid_nxt    = 1'b0;
            pop_event_nxt    = 1'b1;
            event_cnt_nxt    = event_cnt_r - 1'b1;
            event_rd_ptr_nxt = (event_rd_ptr_r == EVENT_LAST) ? '0 : event_rd_ptr_r + 1'b1;
          end else if (fast_cnt_r != '0) begin
            out_valid_nxt   = 1'b0;
            pop_event_nxt   = 1'b0;
            fast_cnt_nxt    = fast_cnt_r - 1'b1;
            fast_rd_ptr_nxt = (fast_rd_ptr_r == FAST_LAST) ? '0 : fast_rd_ptr_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Fast queue memory: read at the head every cycle, write at the tail on a fast push that passes decimation.
  always_ff @(posedge clk) begin
    if (fast_we) begin
      fast_mem[fast_wr_ptr_r] <= word_in;
    end
    fast_rdata_r <= fast_mem[fast_rd_ptr_r];
  end

  // Event queue memory.
  always_ff @(posedge clk) begin
    if (event_we) begin
      event_mem[event_wr_ptr_r] <= word_in;
    end
    event_rdata_r <= event_mem[event_rd_ptr_r];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      fast_rd_ptr_r  <= '0;
      fast_wr_ptr_r  <= '0;
      fast_cnt_r     <= '0;
      event_rd_ptr_r <= '0;
      event_wr_ptr_r <= '0;
      event_cnt_r    <= '0;
      decim_cnt_r    <= '0;
      decim_cfg_r    <= DECIM_W'(1);
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      fast_rd_ptr_r  <= fast_rd_ptr_nxt;
      fast_wr_ptr_r  <= fast_wr_ptr_nxt;
      fast_cnt_r     <= fast_cnt_nxt;
      event_rd_ptr_r <= event_rd_ptr_nxt;
      event_wr_ptr_r <= event_wr_ptr_nxt;
      event_cnt_r    <= event_cnt_nxt;
      decim_cnt_r    <= decim_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        decim_cfg_r <= cfg_data;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk) begin
    pop_event_r  <= pop_event_nxt;
    pop_valid_r  <= pop_valid_nxt;
    packet_r     <= packet_nxt;
    from_event_r <= from_event_nxt;
    displaced_r  <= displaced_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_pop_valid        = pop_valid_r;
  assign out_packet_out       = packet_r;
  assign out_from_event_class = from_event_r;
  assign out_displaced        = displaced_r;
  assign out_fast_fill        = FAST_FILL_W'(fast_cnt_r);
  assign out_event_fill       = EVENT_FILL_W'(event_cnt_r);

endmodule
